@@ src/pld_pkg.sv @@
// Package with the shared sizes of the point-to-line distance block.
`timescale 1ns / 1ps
`default_nettype none
package pld_pkg;

	// Width of the distance result, in input LSBs.
	localparam int DIST_BITS = 17;

	// Default coordinate width.
	localparam int COORD_BITS_DEF = 16;

endpackage
`default_nettype wire

@@ src/pld_in_if.sv @@
// Query channel: the point and the two line endpoints.
`timescale 1ns / 1ps
`default_nettype none
interface pld_in_if
	import pld_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] point_x;
	logic [COORD_BITS-1:0] point_y;
	logic [COORD_BITS-1:0] point_z;
	logic [COORD_BITS-1:0] start_x;
	logic [COORD_BITS-1:0] start_y;
	logic [COORD_BITS-1:0] start_z;
	logic [COORD_BITS-1:0] end_x;
	logic [COORD_BITS-1:0] end_y;
	logic [COORD_BITS-1:0] end_z;

	modport source (
		output valid, point_x, point_y, point_z, start_x, start_y, start_z,
			end_x, end_y, end_z,
		input  ready
	);
	modport sink (
		input  valid, point_x, point_y, point_z, start_x, start_y, start_z,
			end_x, end_y, end_z,
		output ready
	);
endinterface
`default_nettype wire

@@ src/pld_out_if.sv @@
// Result channel: the distance and the degenerate flag.
`timescale 1ns / 1ps
`default_nettype none
interface pld_out_if
	import pld_pkg::*;
;
	logic                 valid;
	logic                 ready;
	logic [DIST_BITS-1:0] distance;
	logic                 degenerate;

	modport source (output valid, distance, degenerate, input ready);
	modport sink (input valid, distance, degenerate, output ready);
endinterface
`default_nettype wire

@@ src/point_line_distance_3d.sv @@
// Top level of the point-to-line distance block.
// Streams one query per clock: an item enters every cycle while results are taken,
// and its result leaves after six front stages of products and differences, then
// one chain cell per distance bit. The distance is the exact perpendicular
// distance floored to the input LSB and saturated at 17 bits; when the endpoints
// coincide the distance is 0 and degenerate is set. A waiting result does not stop
// the block from taking items while a stage further up is empty.
`timescale 1ns / 1ps
`default_nettype none
module point_line_distance_3d
	import pld_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	pld_in_if.sink    query,
	pld_out_if.source result
);
	localparam int SW = 2 * COORD_BITS + 2;
	localparam int NW = 2 * SW;
	localparam int EW = SW + DIST_BITS;

	logic                 c_valid [DIST_BITS+1];
	logic                 c_ready [DIST_BITS+1];
	logic [NW-1:0]        c_r     [DIST_BITS+1];
	logic [EW-1:0]        c_e     [DIST_BITS+1];
	logic [SW-1:0]        c_dd    [DIST_BITS+1];
	logic [DIST_BITS-1:0] c_d     [DIST_BITS+1];
	logic                 c_degen [DIST_BITS+1];

	// Front pipeline feeds the root chain.
	pld_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (query.valid),
		.in_ready  (query.ready),
		.px        (query.point_x),
		.py        (query.point_y),
		.pz        (query.point_z),
		.sx        (query.start_x),
		.sy        (query.start_y),
		.sz        (query.start_z),
		.ex        (query.end_x),
		.ey        (query.end_y),
		.ez        (query.end_z),
		.out_valid (c_valid[0]),
		.out_ready (c_ready[0]),
		.num       (c_r[0]),
		.dd        (c_dd[0]),
		.degen     (c_degen[0])
	);

	assign c_e[0] = '0;
	assign c_d[0] = '0;

	// Chain of cells, most significant distance bit first.
	for (genvar k = 0; k < DIST_BITS; k++) begin : g_cell
		pld_sqrt_cell #(
			.COORD_BITS (COORD_BITS),
			.BIT        (DIST_BITS - 1 - k)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (c_valid[k]),
			.in_ready  (c_ready[k]),
			.r_in      (c_r[k]),
			.e_in      (c_e[k]),
			.dd_in     (c_dd[k]),
			.d_in      (c_d[k]),
			.degen_in  (c_degen[k]),
			.out_valid (c_valid[k+1]),
			.out_ready (c_ready[k+1]),
			.r_out     (c_r[k+1]),
			.e_out     (c_e[k+1]),
			.dd_out    (c_dd[k+1]),
			.d_out     (c_d[k+1]),
			.degen_out (c_degen[k+1])
		);
	end

	// The last cell is the output register.
	assign c_ready[DIST_BITS] = result.ready;
	assign result.valid       = c_valid[DIST_BITS];
	assign result.degenerate  = c_degen[DIST_BITS];
	assign result.distance    = c_degen[DIST_BITS] ? '0 : c_d[DIST_BITS];

	// A drained output lets the whole pipeline move.
	assert property (@(posedge clk) disable iff (!arst_n)
		result.ready |-> query.ready)
		else $error("query stalled while the result side is ready");

	// A stalled front result holds until the chain takes it.
	assert property (@(posedge clk) disable iff (!arst_n)
		c_valid[0] && !c_ready[0] |=> c_valid[0] && $stable(c_r[0]) && $stable(c_dd[0]))
		else $error("front output changed while stalled");

	// A degenerate item always carries a zero divisor.
	assert property (@(posedge clk) disable iff (!arst_n)
		c_valid[DIST_BITS] && c_degen[DIST_BITS] |-> c_dd[DIST_BITS] == '0)
		else $error("degenerate flag with non-zero divisor");
endmodule
`default_nettype wire

@@ src/pld_front.sv @@
// Front pipeline: differences, dot products and the exact squared-distance numerator.
`timescale 1ns / 1ps
`default_nettype none
module pld_front
	import pld_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	localparam int SW = 2 * COORD_BITS + 2,
	localparam int NW = 2 * SW
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [COORD_BITS-1:0] px,
	input  wire logic [COORD_BITS-1:0] py,
	input  wire logic [COORD_BITS-1:0] pz,
	input  wire logic [COORD_BITS-1:0] sx,
	input  wire logic [COORD_BITS-1:0] sy,
	input  wire logic [COORD_BITS-1:0] sz,
	input  wire logic [COORD_BITS-1:0] ex,
	input  wire logic [COORD_BITS-1:0] ey,
	input  wire logic [COORD_BITS-1:0] ez,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [NW-1:0]              num,
	output logic [SW-1:0]              dd,
	output logic                       degen
);
	localparam int C  = COORD_BITS;
	localparam int NS = 6;
	localparam int H  = (SW + 1) / 2;
	localparam int HI = SW - H;

	logic [NS-1:0] v_q;
	logic [NS-1:0] en;

	// Each stage moves when it is empty or its successor moves.
	always_comb begin
		en[NS-1] = !v_q[NS-1] || out_ready;
		for (int k = NS - 2; k >= 0; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end

	assign in_ready  = en[0];
	assign out_valid = v_q[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) begin
				v_q[0] <= in_valid;
			end
			for (int k = 1; k < NS; k++) begin
				if (en[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	// Stage 1: w = P - S and d = E - S.
	logic signed [C:0] w_s1 [3];
	logic signed [C:0] d_s1 [3];
	logic [C-1:0] p_c [3];
	logic [C-1:0] s_c [3];
	logic [C-1:0] e_c [3];

	assign p_c = '{px, py, pz};
	assign s_c = '{sx, sy, sz};
	assign e_c = '{ex, ey, ez};

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < 3; i++) begin
				w_s1[i] <= $signed({p_c[i][C-1], p_c[i]}) - $signed({s_c[i][C-1], s_c[i]});
				d_s1[i] <= $signed({e_c[i][C-1], e_c[i]}) - $signed({s_c[i][C-1], s_c[i]});
			end
		end
	end

	// Stage 2: magnitudes, squares and the component products of w and d.
	logic [2*C-1:0] sqw_s2 [3];
	logic [2*C-1:0] sqd_s2 [3];
	logic [2*C-1:0] crs_s2 [3];
	logic [2:0]     neg_s2;
	logic           degen_s2;
	logic [C:0]     nw [3];
	logic [C:0]     nd [3];
	logic [C-1:0]   aw [3];
	logic [C-1:0]   ad [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nw[i] = w_s1[i][C] ? (~w_s1[i] + 1'b1) : w_s1[i];
			nd[i] = d_s1[i][C] ? (~d_s1[i] + 1'b1) : d_s1[i];
			aw[i] = nw[i][C-1:0];
			ad[i] = nd[i][C-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int i = 0; i < 3; i++) begin
				sqw_s2[i] <= aw[i] * aw[i];
				sqd_s2[i] <= ad[i] * ad[i];
				crs_s2[i] <= aw[i] * ad[i];
				neg_s2[i] <= w_s1[i][C] ^ d_s1[i][C];
			end
			degen_s2 <= (d_s1[0] == '0) && (d_s1[1] == '0) && (d_s1[2] == '0);
		end
	end

	// Stage 3: |w|^2, |d|^2 and |w.d|.
	logic [SW-1:0] ww_s3;
	logic [SW-1:0] dd_s3;
	logic [SW-1:0] wd_s3;
	logic          degen_s3;
	logic [SW-1:0] pos_sum;
	logic [SW-1:0] neg_sum;

	always_comb begin
		pos_sum = '0;
		neg_sum = '0;
		for (int i = 0; i < 3; i++) begin
			if (neg_s2[i]) begin
				neg_sum = neg_sum + SW'(crs_s2[i]);
			end else begin
				pos_sum = pos_sum + SW'(crs_s2[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			ww_s3    <= SW'(sqw_s2[0]) + SW'(sqw_s2[1]) + SW'(sqw_s2[2]);
			dd_s3    <= SW'(sqd_s2[0]) + SW'(sqd_s2[1]) + SW'(sqd_s2[2]);
			wd_s3    <= (pos_sum >= neg_sum) ? (pos_sum - neg_sum) : (neg_sum - pos_sum);
			degen_s3 <= degen_s2;
		end
	end

	// Stage 4: partial products of |w|^2 |d|^2 and (w.d)^2 on half words.
	logic [2*H-1:0]  a_ll_s4, b_ll_s4;
	logic [H+HI-1:0] a_lh_s4, a_hl_s4, b_lh_s4, b_hl_s4;
	logic [2*HI-1:0] a_hh_s4, b_hh_s4;
	logic [SW-1:0]   dd_s4;
	logic            degen_s4;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			a_ll_s4  <= ww_s3[H-1:0] * dd_s3[H-1:0];
			a_lh_s4  <= ww_s3[H-1:0] * dd_s3[SW-1:H];
			a_hl_s4  <= ww_s3[SW-1:H] * dd_s3[H-1:0];
			a_hh_s4  <= ww_s3[SW-1:H] * dd_s3[SW-1:H];
			b_ll_s4  <= wd_s3[H-1:0] * wd_s3[H-1:0];
			b_lh_s4  <= wd_s3[H-1:0] * wd_s3[SW-1:H];
			b_hl_s4  <= wd_s3[SW-1:H] * wd_s3[H-1:0];
			b_hh_s4  <= wd_s3[SW-1:H] * wd_s3[SW-1:H];
			dd_s4    <= dd_s3;
			degen_s4 <= degen_s3;
		end
	end

	// Stage 5: the two full products.
	logic [NW-1:0] pa_s5, pb_s5;
	logic [SW-1:0] dd_s5;
	logic          degen_s5;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			pa_s5 <= NW'(a_ll_s4) + ((NW'(a_lh_s4) + NW'(a_hl_s4)) << H)
				+ (NW'(a_hh_s4) << (2 * H));
			pb_s5 <= NW'(b_ll_s4) + ((NW'(b_lh_s4) + NW'(b_hl_s4)) << H)
				+ (NW'(b_hh_s4) << (2 * H));
			dd_s5    <= dd_s4;
			degen_s5 <= degen_s4;
		end
	end

	// Stage 6: numerator |w|^2 |d|^2 - (w.d)^2, never below zero.
	logic [NW-1:0] num_s6;
	logic [SW-1:0] dd_s6;
	logic          degen_s6;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			num_s6   <= (pa_s5 >= pb_s5) ? (pa_s5 - pb_s5) : '0;
			dd_s6    <= dd_s5;
			degen_s6 <= degen_s5;
		end
	end

	assign num   = num_s6;
	assign dd    = dd_s6;
	assign degen = degen_s6;
endmodule
`default_nettype wire

@@ src/pld_sqrt_cell.sv @@
// One cell of the root chain: settles one bit of the distance.
`timescale 1ns / 1ps
`default_nettype none
module pld_sqrt_cell
	import pld_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int BIT = 0,
	localparam int SW = 2 * COORD_BITS + 2,
	localparam int NW = 2 * SW,
	localparam int EW = SW + DIST_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [NW-1:0]        r_in,
	input  wire logic [EW-1:0]        e_in,
	input  wire logic [SW-1:0]        dd_in,
	input  wire logic [DIST_BITS-1:0] d_in,
	input  wire logic                 degen_in,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [NW-1:0]             r_out,
	output logic [EW-1:0]             e_out,
	output logic [SW-1:0]             dd_out,
	output logic [DIST_BITS-1:0]      d_out,
	output logic                      degen_out
);
	localparam int XW = EW + DIST_BITS + 1;
	localparam int CW = (XW > NW) ? XW : NW;

	logic          valid_q;
	logic          en;
	logic [CW-1:0] trial;
	logic [CW-1:0] r_ext;
	logic [CW-1:0] diff;
	logic          fits;

	assign en       = !valid_q || out_ready;
	assign in_ready = en;

	// Setting this bit grows D^2 dd by 2^(b+1) D dd + 2^(2b) dd; keep it if the rest allows.
	always_comb begin
		trial = (CW'(e_in) << (BIT + 1)) + (CW'(dd_in) << (2 * BIT));
		r_ext = CW'(r_in);
		fits  = trial <= r_ext;
		diff  = r_ext - trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_out     <= fits ? diff[NW-1:0] : r_in;
			e_out     <= fits ? (e_in + (EW'(dd_in) << BIT)) : e_in;
			d_out     <= fits ? (d_in | (DIST_BITS'(1) << BIT)) : d_in;
			dd_out    <= dd_in;
			degen_out <= degen_in;
		end
	end

	assign out_valid = valid_q;
endmodule
`default_nettype wire
